// File: src/rsld_pkg.sv
// Shared types and constants for the run-length sprite line decoder.
package rsld_pkg;

   localparam int BYTE_W     = 8;
   localparam int COUNT_W    = 16;
   localparam int XOUT_W     = 12;
   localparam int ADV_W      = 16;
   localparam int SPRITE_X_W = 11;
   localparam int HDR_LEN_W  = 5;

   localparam logic [HDR_LEN_W-1:0] LEN_EXTEND  = 5'd31;
   localparam logic [BYTE_W-1:0]    BYTE_EXTEND = 8'd255;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_EXTEND = 2'd1,
      PH_DATA   = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      MODE_SKIP = 2'd0,
      MODE_FILL = 2'd1,
      MODE_COPY = 2'd2,
      MODE_BACK = 2'd3
   } mode_type;

   typedef struct packed {
      logic               load;
      logic               emit;
      logic               adv_first;
      logic               eol;
      logic [ADV_W-1:0]   adv;
      logic [COUNT_W-1:0] count;
      logic [BYTE_W-1:0]  value;
   } op_type;

endpackage

// File: src/rsld_front.sv
// Front end: parses header, length extension and data bytes into position ops.
module rsld_front #(
   parameter int LENGTH_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            stream_byte,
   input  logic                  line_start,
   output logic                  push,
   output rsld_pkg::op_type      op
);
   import rsld_pkg::*;

   phase_type              phase_ff, phase_in;
   mode_type               mode_ff, mode_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic                   eol_ff, eol_in;

   logic [LENGTH_BITS:0]   sum;
   logic [LENGTH_BITS-1:0] len_sat;
   logic [LENGTH_BITS-1:0] len_cmd;
   mode_type               mode_cmd;
   logic                   eol_cmd;
   logic                   start_cmd;
   logic                   copy_last;
   phase_type              ph;

   assign sum       = {1'b0, len_ff} + (LENGTH_BITS+1)'(stream_byte);
   assign len_sat   = sum[LENGTH_BITS] ? {LENGTH_BITS{1'b1}} : sum[LENGTH_BITS-1:0];
   assign copy_last = (len_ff <= LENGTH_BITS'(1));
   assign ph        = line_start ? PH_HEADER : phase_ff;

   always_comb begin
      phase_in  = phase_ff;
      mode_in   = mode_ff;
      len_in    = len_ff;
      eol_in    = eol_ff;
      start_cmd = 1'b0;
      mode_cmd  = mode_ff;
      len_cmd   = len_ff;
      eol_cmd   = eol_ff;
      op        = '0;
      op.load   = line_start;

      unique case (ph)
         PH_EXTEND: begin
            len_in = len_sat;
            if (stream_byte != BYTE_EXTEND) begin
               start_cmd = 1'b1;
               len_cmd   = len_sat;
            end
         end
         PH_DATA: begin
            phase_in = PH_HEADER;
            unique case (mode_ff)
               MODE_FILL: begin
                  op.emit  = 1'b1;
                  op.count = COUNT_W'(len_ff);
                  op.value = stream_byte;
                  op.eol   = eol_ff;
                  op.adv   = ADV_W'(len_ff);
               end
               MODE_COPY: begin
                  op.emit  = 1'b1;
                  op.count = COUNT_W'(1);
                  op.value = stream_byte;
                  op.eol   = eol_ff & copy_last;
                  op.adv   = ADV_W'(1);
                  len_in   = copy_last ? '0 : len_ff - LENGTH_BITS'(1);
                  if (!copy_last) begin
                     phase_in = PH_DATA;
                  end
               end
               MODE_BACK: begin
                  op.adv       = ADV_W'({len_ff >> 3, 1'b0});
                  op.adv_first = 1'b1;
                  op.emit      = eol_ff;
                  op.eol       = 1'b1;
               end
               default: ;
            endcase
         end
         default: begin
            mode_in  = mode_type'(stream_byte[7:6]);
            eol_in   = stream_byte[5];
            len_in   = LENGTH_BITS'(stream_byte[4:0]);
            mode_cmd = mode_type'(stream_byte[7:6]);
            eol_cmd  = stream_byte[5];
            len_cmd  = LENGTH_BITS'(stream_byte[4:0]);
            if (stream_byte[4:0] == LEN_EXTEND) begin
               phase_in = PH_EXTEND;
            end else begin
               start_cmd = 1'b1;
            end
         end
      endcase

      if (start_cmd) begin
         unique case (mode_cmd)
            MODE_SKIP: begin
               phase_in     = PH_HEADER;
               op.adv       = ADV_W'(len_cmd);
               op.adv_first = 1'b1;
               op.emit      = eol_cmd;
               op.eol       = 1'b1;
            end
            MODE_COPY: begin
               if (len_cmd == '0) begin
                  phase_in = PH_HEADER;
                  op.emit  = eol_cmd;
                  op.eol   = 1'b1;
               end else begin
                  phase_in = PH_DATA;
               end
            end
            default: phase_in = PH_DATA;
         endcase
      end
   end

   assign push = accept & (op.load | op.emit | (op.adv != '0));

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         mode_ff  <= MODE_SKIP;
         len_ff   <= '0;
         eol_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         mode_ff  <= mode_in;
         len_ff   <= len_in;
         eol_ff   <= eol_in;
      end
   end

endmodule

// File: src/rsld_queue.sv
// Small op queue between the parser and the span generator.
module rsld_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rsld_pkg::op_type push_op,
   output logic             full,
   input  logic             pop,
   output rsld_pkg::op_type head_op,
   output logic             empty
);
   import rsld_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   op_type           slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign head_op = slot_ff[rd_ff];

   always_comb begin
      wr_in  = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      rd_in  = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      cnt_in = cnt_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_in;
         if (do_pop)  rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_op;
      end
   end

endmodule

// File: src/rsld_back.sv
// Back end: tracks the x position, applies ops and holds the output span beat.
module rsld_back #(
   parameter int X_BITS = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [rsld_pkg::SPRITE_X_W-1:0]       csr_data,
   input  logic                                  op_avail,
   input  rsld_pkg::op_type                      op,
   output logic                                  op_pop,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic [rsld_pkg::XOUT_W-1:0]           out_x,
   output logic [rsld_pkg::COUNT_W-1:0]          out_count,
   output logic [rsld_pkg::BYTE_W-1:0]           out_value,
   output logic                                  out_eol
);
   import rsld_pkg::*;

   logic [SPRITE_X_W-1:0] sprite_x_ff;
   logic [X_BITS-1:0]     x_ff;
   logic [X_BITS-1:0]     x_base, x_new, x_emit;
   logic                  valid_ff;
   logic [XOUT_W-1:0]     x_out_ff;
   logic [COUNT_W-1:0]    count_ff;
   logic [BYTE_W-1:0]     value_ff;
   logic                  eol_ff;

   assign op_pop = op_avail & (~valid_ff | out_ready);
   assign x_base = op.load ? X_BITS'(signed'(sprite_x_ff)) : x_ff;
   assign x_new  = x_base + X_BITS'(op.adv);
   assign x_emit = op.adv_first ? x_new : x_base;

   always_ff @(posedge clock) begin
      if (reset) begin
         sprite_x_ff <= '0;
         x_ff        <= '0;
         valid_ff    <= 1'b0;
      end else begin
         if (csr_write) sprite_x_ff <= csr_data;
         if (op_pop) begin
            x_ff     <= x_new;
            valid_ff <= op.emit;
         end else if (out_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (op_pop && op.emit) begin
         x_out_ff <= XOUT_W'(x_emit);
         count_ff <= op.count;
         value_ff <= op.value;
         eol_ff   <= op.eol;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_out_ff;
   assign out_count = count_ff;
   assign out_value = value_ff;
   assign out_eol   = eol_ff;

endmodule

// File: src/rle_sprite_line_decoder.sv
// Top level of the run-length sprite line decoder.
//
// req channel: one beat per byte of the coded sprite stream; req_tuser marks
// the first byte of a line and reloads x from the sprite_x register.
// rsp channel: one beat per pixel span (x, count, value); rsp_tlast flags the
// last span of a coded line, a zero-count beat when the line ends on no span.
// csr channel: writes sprite_x; the user must write it only while the decoder is idle, the block does not enforce this.
// Throughput: one byte per cycle while rsp is not stalled and the queue is not full, set
// by the parser taking a byte each cycle and the span stage retiring one queued op each cycle.
// A taken byte's op passes through the op queue and then the output register, which raises
// rsp_tvalid for the span beat; ops queued ahead of it delay the beat further.
// When rsp stalls the span stays in the output register and ops build up in a
// four-entry queue; req_tready drops once the queue is full.
// Reset clears parser state, queue, x position, sprite_x and rsp_tvalid.
module rle_sprite_line_decoder #(
   parameter int X_BITS      = 12,
   parameter int LENGTH_BITS = 16,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] stream_byte
   input  logic        req_tuser,   // [0] line_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [11:0] x_start, [27:12] pixel_count, [35:28] pixel_value
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_data
);
   import rsld_pkg::*;

   logic               accept;
   logic               push;
   logic               full;
   logic               empty;
   logic               pop;
   op_type             push_op;
   op_type             head_op;
   logic [XOUT_W-1:0]  out_x;
   logic [COUNT_W-1:0] out_count;
   logic [BYTE_W-1:0]  out_value;

   assign req_tready = ~full;
   assign accept     = req_tvalid & ~full;
   assign csr_ready  = 1'b1;

   rsld_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .stream_byte (req_tdata),
      .line_start  (req_tuser),
      .push        (push),
      .op          (push_op)
   );

   rsld_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .full    (full),
      .pop     (pop),
      .head_op (head_op),
      .empty   (empty)
   );

   rsld_back #(.X_BITS(X_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid),
      .csr_data  (csr_data),
      .op_avail  (~empty),
      .op        (head_op),
      .op_pop    (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_x     (out_x),
      .out_count (out_count),
      .out_value (out_value),
      .out_eol   (rsp_tlast)
   );

   assign rsp_tdata = {4'b0, out_value, out_count, out_x};

endmodule
